@@ rtl/pr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pr_pkg;

	localparam int AW = 35;
	localparam int ZW = 33;
	localparam int CW = 32;

	localparam logic signed [AW-1:0] ANG_PI      = 35'sd3373259426;
	localparam logic signed [AW-1:0] ANG_TWO_PI  = 35'sd6746518852;
	localparam logic signed [AW-1:0] ANG_HALF_PI = 35'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_K    = 32'sd163008219;

	typedef logic [1:0] frame_t;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [15:0] heading;
		frame_t             frame;
		logic               mismatch;
		logic               bypass;
		logic               flip;
	} pr_side_t;

	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] k);
		logic signed [ZW-1:0] v;
		unique case (k)
			5'd0:  v = 33'sh03243F6A8;
			5'd1:  v = 33'sh01DAC6705;
			5'd2:  v = 33'sh00FADBAFC;
			5'd3:  v = 33'sh007F56EA6;
			5'd4:  v = 33'sh003FEAB76;
			5'd5:  v = 33'sh001FFD55B;
			5'd6:  v = 33'sh000FFFAAA;
			5'd7:  v = 33'sh0007FFF55;
			5'd8:  v = 33'sh0003FFFEA;
			5'd9:  v = 33'sh0001FFFFD;
			5'd10: v = 33'sh0000FFFFF;
			5'd11: v = 33'sh00007FFFF;
			5'd12: v = 33'sh00003FFFF;
			5'd13: v = 33'sh00001FFFF;
			5'd14: v = 33'sh00000FFFF;
			5'd15: v = 33'sh000007FFF;
			5'd16: v = 33'sh000003FFF;
			5'd17: v = 33'sh000001FFF;
			5'd18: v = 33'sh000000FFF;
			5'd19: v = 33'sh0000007FF;
			5'd20: v = 33'sh0000003FF;
			5'd21: v = 33'sh0000001FF;
			5'd22: v = 33'sh0000000FF;
			5'd23: v = 33'sh00000007F;
			5'd24: v = 33'sh00000003F;
			5'd25: v = 33'sh00000001F;
			5'd26: v = 33'sh00000000F;
			5'd27: v = 33'sh000000007;
			5'd28: v = 33'sh000000003;
			5'd29: v = 33'sh000000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/pr_pose_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pr_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [15:0] point_heading;
	logic [1:0]         point_frame;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [15:0] center_heading;
	logic [1:0]         center_frame;

	modport source (
		output valid, point_x, point_y, point_heading, point_frame,
		output center_x, center_y, center_heading, center_frame,
		input  ready
	);

	modport sink (
		input  valid, point_x, point_y, point_heading, point_frame,
		input  center_x, center_y, center_heading, center_frame,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/pr_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pr_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] rotated_x;
	logic signed [31:0] rotated_y;
	logic signed [15:0] result_heading;
	logic [1:0]         result_frame;
	logic               frame_mismatch;

	modport source (
		output valid, rotated_x, rotated_y, result_heading, result_frame, frame_mismatch,
		input  ready
	);

	modport sink (
		input  valid, rotated_x, rotated_y, result_heading, result_frame, frame_mismatch,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/pr_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pr_cordic
	import pr_pkg::*;
#(
	parameter int ITER = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [ZW-1:0] in_z,
	input  wire pr_side_t             in_side,
	output logic                      out_valid,
	output logic signed [CW-1:0]      out_x,
	output logic signed [CW-1:0]      out_y,
	output pr_side_t                  out_side
);

	logic signed [CW-1:0] x_w [ITER+1];
	logic signed [CW-1:0] y_w [ITER+1];
	logic signed [ZW-1:0] z_w [ITER+1];
	logic                 v_w [ITER+1];
	pr_side_t             side_w [ITER+1];

	assign x_w[0]    = CORDIC_K;
	assign y_w[0]    = '0;
	assign z_w[0]    = in_z;
	assign v_w[0]    = in_valid;
	assign side_w[0] = in_side;

	for (genvar i = 0; i < ITER; i++) begin : g_stage
		localparam logic [4:0] K = 5'(i);
		logic signed [CW-1:0] x_s;
		logic signed [CW-1:0] y_s;
		logic signed [ZW-1:0] z_s;
		logic                 v_s;
		pr_side_t             side_s;
		logic signed [CW-1:0] xsh;
		logic signed [CW-1:0] ysh;

		assign xsh = x_w[i] >>> K;
		assign ysh = y_w[i] >>> K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s <= 1'b0;
			end else if (en) begin
				v_s <= v_w[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s <= side_w[i];
				if (!z_w[i][ZW-1]) begin
					x_s <= x_w[i] - ysh;
					y_s <= y_w[i] + xsh;
					z_s <= z_w[i] - atan_q30(K);
				end else begin
					x_s <= x_w[i] + ysh;
					y_s <= y_w[i] - xsh;
					z_s <= z_w[i] + atan_q30(K);
				end
			end
		end

		assign x_w[i+1]    = x_s;
		assign y_w[i+1]    = y_s;
		assign z_w[i+1]    = z_s;
		assign v_w[i+1]    = v_s;
		assign side_w[i+1] = side_s;
	end

	assign out_valid = v_w[ITER];
	assign out_x     = x_w[ITER];
	assign out_y     = y_w[ITER];
	assign out_side  = side_w[ITER];

endmodule

`default_nettype wire

@@ rtl/pose_rotate_about_center_core.sv @@
// Rotates a point pose about a center pose by the center's heading.
// Input channel pose: point x/y/heading/frame and center x/y/heading/frame, one
// transaction per pose pair. Output channel result: rotated x/y, saturated summed
// heading (the point's own on mismatch), point frame, mismatch flag, one per input.
// Throughput: one transaction per cycle while the receiver takes results, with no
// dependency between items; the datapath is a fully pipelined CORDIC with one stage
// per iteration. The accepting edge loads the first of CORDIC_ITERATIONS + 6
// register stages: angle reduction and fold (2), the CORDIC stages, sign correction,
// the product stage, the rounding sum and the final offset and saturation stage,
// which drives result.valid.
// Zero angle or a frame mismatch passes the point coordinates through.
// Reset clears every stage valid bit; the pipeline comes up empty and ready.
// When the receiver stalls, the whole pipeline holds and pose.ready drops only
// while the last stage holds a result that is not taken; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module pose_rotate_about_center_core
	import pr_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pr_pose_if.sink      pose,
	pr_result_if.source  result
);

	logic en;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [AW-1:0] ang_s1;
	pr_side_t             side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic signed [ZW-1:0] z_s2;
	logic signed [CW-1:0] c_s3, s_s3;
	logic signed [64:0]   pxc_s4, pys_s4, pxs_s4, pyc_s4;
	logic signed [37:0]   rxs_s5, rys_s5;
	logic signed [31:0]   rx_s6, ry_s6;

	logic                 cv;
	logic signed [CW-1:0] cx_w, cy_w;
	pr_side_t             cside;

	logic signed [AW-1:0] ang_in;
	logic signed [AW-1:0] ang_red;
	logic signed [16:0]   hsum;
	logic signed [15:0]   hsat;
	pr_side_t             side_in;
	logic signed [ZW-1:0] z_fold;
	pr_side_t             side_fold;
	logic signed [65:0]   sumx, sumy;
	logic signed [38:0]   tx, ty;

	localparam logic signed [65:0] HALF = 66'sd134217728;

	function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
		logic signed [31:0] r;
		if (v > 39'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -39'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign en         = !v_s6 || result.ready;
	assign pose.ready = en;

	always_comb begin
		ang_in = AW'($signed({pose.center_heading, 18'b0}));
		if (ang_in > ANG_PI) begin
			ang_red = ang_in - ANG_TWO_PI;
		end else if (ang_in < -ANG_PI) begin
			ang_red = ang_in + ANG_TWO_PI;
		end else begin
			ang_red = ang_in;
		end
		hsum = 17'(pose.point_heading) + 17'(pose.center_heading);
		if (hsum > 17'sd32767) begin
			hsat = 16'sh7FFF;
		end else if (hsum < -17'sd32768) begin
			hsat = 16'sh8000;
		end else begin
			hsat = hsum[15:0];
		end
		side_in.dx       = 33'(pose.point_x) - 33'(pose.center_x);
		side_in.dy       = 33'(pose.point_y) - 33'(pose.center_y);
		side_in.px       = pose.point_x;
		side_in.py       = pose.point_y;
		side_in.cx       = pose.center_x;
		side_in.cy       = pose.center_y;
		side_in.frame    = pose.point_frame;
		side_in.mismatch = pose.point_frame != pose.center_frame;
		side_in.heading  = side_in.mismatch ? pose.point_heading : hsat;
		side_in.bypass   = side_in.mismatch || (pose.center_heading == 16'sd0);
		side_in.flip     = 1'b0;
	end

	always_comb begin
		side_fold = side_s1;
		if (ang_s1 > ANG_HALF_PI) begin
			z_fold         = ZW'(ang_s1 - ANG_PI);
			side_fold.flip = 1'b1;
		end else if (ang_s1 < -ANG_HALF_PI) begin
			z_fold         = ZW'(ang_s1 + ANG_PI);
			side_fold.flip = 1'b1;
		end else begin
			z_fold         = ZW'(ang_s1);
			side_fold.flip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= pose.valid;
			v_s2 <= v_s1;
			v_s3 <= cv;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		sumx = 66'(pxc_s4) - 66'(pys_s4) + HALF;
		sumy = 66'(pxs_s4) + 66'(pyc_s4) + HALF;
		tx   = 39'(rxs_s5) + 39'(side_s5.cx);
		ty   = 39'(rys_s5) + 39'(side_s5.cy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1  <= ang_red;
			side_s1 <= side_in;

			side_s2 <= side_fold;
			z_s2    <= z_fold;

			side_s3 <= cside;
			c_s3    <= cside.flip ? -cx_w : cx_w;
			s_s3    <= cside.flip ? -cy_w : cy_w;

			side_s4 <= side_s3;
			pxc_s4  <= side_s3.dx * c_s3;
			pys_s4  <= side_s3.dy * s_s3;
			pxs_s4  <= side_s3.dx * s_s3;
			pyc_s4  <= side_s3.dy * c_s3;

			side_s5 <= side_s4;
			rxs_s5  <= sumx[65:28];
			rys_s5  <= sumy[65:28];

			side_s6 <= side_s5;
			rx_s6   <= side_s5.bypass ? side_s5.px : sat32(tx);
			ry_s6   <= side_s5.bypass ? side_s5.py : sat32(ty);
		end
	end

	pr_cordic #(
		.ITER (CORDIC_ITERATIONS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_z      (z_s2),
		.in_side   (side_s2),
		.out_valid (cv),
		.out_x     (cx_w),
		.out_y     (cy_w),
		.out_side  (cside)
	);

	assign result.valid          = v_s6;
	assign result.rotated_x      = rx_s6;
	assign result.rotated_y      = ry_s6;
	assign result.result_heading = side_s6.heading;
	assign result.result_frame   = side_s6.frame;
	assign result.frame_mismatch = side_s6.mismatch;

endmodule

`default_nettype wire
